/* hw/rtl/cfe_pkg.sv */
// Shared types, constants and the CRC byte update for the framed packet encoder.
package cfe_pkg;

  localparam int unsigned MaxPayload = 1024;
  localparam int unsigned FifoDepthDefault = 4;

  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam logic [15:0] CrcInit = 16'hFFFF;

  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusTooLong = 2'd1;
  localparam logic [1:0] StatusNoFrame = 2'd2;

  typedef struct packed {
    logic        op;
    logic [7:0]  frame_type;
    logic [15:0] sequence_req;
    logic [15:0] payload_length;
    logic [7:0]  payload_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_frame;
    logic [1:0] status;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_BEGIN,
    CMD_PAY,
    CMD_ERR
  } cmd_kind_e;

  // One classified item waiting for the byte sequencer.
  typedef struct packed {
    cmd_kind_e   kind;
    logic        last;     // frame closes after this item
    logic [1:0]  status;   // error code for CMD_ERR
    logic [7:0]  data;     // frame type, or the payload byte
    logic [15:0] seq;
    logic [15:0] len;
  } cmd_t;

  // CRC-16/CCITT-FALSE, one byte, MSB first.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* hw/rtl/cfe_front.sv */
// Front end: accepts input items, tracks frame state and classifies each item.
module cfe_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  cfe_pkg::in_item_t item_i,
  output cfe_pkg::cmd_t    cmd_o
);

  logic        open_q, open_d;
  logic [15:0] remaining_q, remaining_d;

  always_comb begin
    open_d      = open_q;
    remaining_d = remaining_q;
    cmd_o.kind   = cfe_pkg::CMD_ERR;
    cmd_o.last   = 1'b0;
    cmd_o.status = cfe_pkg::StatusOk;
    cmd_o.data   = item_i.frame_type;
    cmd_o.seq    = item_i.sequence_req;
    cmd_o.len    = item_i.payload_length;

    if (!item_i.op) begin
      if (item_i.payload_length > 16'(cfe_pkg::MaxPayload)) begin
        cmd_o.status = cfe_pkg::StatusTooLong;
      end else begin
        cmd_o.kind = cfe_pkg::CMD_BEGIN;
        if (item_i.payload_length == 16'd0) begin
          cmd_o.last  = 1'b1;
          open_d      = 1'b0;
          remaining_d = 16'd0;
        end else begin
          open_d      = 1'b1;
          remaining_d = item_i.payload_length;
        end
      end
    end else begin
      cmd_o.data = item_i.payload_byte;
      if (!open_q || remaining_q == 16'd0) begin
        cmd_o.status = cfe_pkg::StatusNoFrame;
      end else begin
        cmd_o.kind  = cfe_pkg::CMD_PAY;
        remaining_d = remaining_q - 16'd1;
        if (remaining_q == 16'd1) begin
          cmd_o.last = 1'b1;
          open_d     = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q      <= 1'b0;
      remaining_q <= 16'd0;
    end else if (accept_i) begin
      open_q      <= open_d;
      remaining_q <= remaining_d;
    end
  end

endmodule

/* hw/rtl/cfe_fifo.sv */
// Short command queue between the front end and the byte sequencer.
module cfe_fifo #(
  parameter int unsigned Depth = cfe_pkg::FifoDepthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cfe_pkg::cmd_t cmd_i,
  input  logic          pop_i,
  output cfe_pkg::cmd_t head_o,
  output logic          empty_o,
  output logic          full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  cfe_pkg::cmd_t   entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CntW'(Depth));
  assign head_o  = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/cfe_back.sv */
// Back end: expands queued commands into frame bytes, runs the CRC, holds the output.
module cfe_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        start_byte_i,
  input  cfe_pkg::cmd_t     head_i,
  input  logic              empty_i,
  output logic              pop_o,
  output logic              out_valid_o,
  output cfe_pkg::out_item_t out_o,
  input  logic              out_stall_i
);

  logic [2:0]         step_q, step_d, last_step;
  logic [15:0]        crc_q, crc_d;
  logic               out_valid_q;
  cfe_pkg::out_item_t out_q, out_d;
  logic               emit;

  assign emit = !empty_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_d.out_byte     = 8'h00;
    out_d.end_of_frame = 1'b0;
    out_d.status       = cfe_pkg::StatusOk;
    crc_d              = crc_q;
    last_step          = 3'd0;

    case (head_i.kind)
      cfe_pkg::CMD_BEGIN: begin
        last_step = head_i.last ? 3'd7 : 3'd5;
        case (step_q)
          3'd0: out_d.out_byte = start_byte_i;
          3'd1: out_d.out_byte = head_i.data;
          3'd2: out_d.out_byte = head_i.seq[7:0];
          3'd3: out_d.out_byte = head_i.seq[15:8];
          3'd4: out_d.out_byte = head_i.len[7:0];
          3'd5: out_d.out_byte = head_i.len[15:8];
          3'd6: out_d.out_byte = crc_q[7:0];
          default: begin
            out_d.out_byte     = crc_q[15:8];
            out_d.end_of_frame = 1'b1;
          end
        endcase
        // start byte reseeds, header bytes are covered, CRC high byte closes
        if (step_q == 3'd0 || step_q == 3'd7) begin
          crc_d = cfe_pkg::CrcInit;
        end else if (step_q != 3'd6) begin
          crc_d = cfe_pkg::crc_feed(crc_q, out_d.out_byte);
        end
      end
      cfe_pkg::CMD_PAY: begin
        last_step = head_i.last ? 3'd2 : 3'd0;
        case (step_q)
          3'd0: begin
            out_d.out_byte = head_i.data;
            crc_d          = cfe_pkg::crc_feed(crc_q, head_i.data);
          end
          3'd1: out_d.out_byte = crc_q[7:0];
          default: begin
            out_d.out_byte     = crc_q[15:8];
            out_d.end_of_frame = 1'b1;
            crc_d              = cfe_pkg::CrcInit;
          end
        endcase
      end
      default: begin
        out_d.end_of_frame = 1'b1;
        out_d.status       = head_i.status;
      end
    endcase
  end

  assign pop_o  = emit && (step_q == last_step);
  assign step_d = pop_o ? 3'd0 : step_q + 3'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= 3'd0;
      crc_q       <= cfe_pkg::CrcInit;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        step_q <= step_d;
        crc_q  <= crc_d;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

/* hw/rtl/crc16_frame_encoder_top.sv */
// Framed packet encoder with CRC-16/CCITT-FALSE trailer: top level.
//
// Input channel (in_valid_i / in_i / in_stall_o): a begin item (op 0) yields the
// start byte, type, sequence low/high and length low/high, plus the two CRC bytes
// when the length is zero. A payload item (op 1) yields its byte, plus the CRC
// low and high bytes when it is the last one. Errors yield one zero byte with
// end_of_frame set and a status code.
// Output channel (out_valid_o / out_o / out_stall_i): one byte per cycle unless stalled.
// Config channel (cfg_valid_i / cfg_ready_o / cfg_data_i): start byte value,
// always ready; write it only while the block is idle.
// With the queue empty, an accepted item is written into the command queue and
// its first output byte is then registered in the output register for out_o.
// Bytes: the sequencer emits one per cycle while fed and not stalled; a payload
// item gives one, a begin six (eight with zero length), a closing payload three.
// The command queue (FifoDepth entries) absorbs header and trailer bursts;
// in_stall_o rises only when that queue is full.
// When out_stall_i is high with an item shown, the output register holds it and
// the sequencer waits; the front keeps accepting until the queue fills.
// Reset: no frame open, CRC seeded with all ones, start byte zero, queue empty.
module crc16_frame_encoder_top #(
  parameter int unsigned FifoDepth = cfe_pkg::FifoDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  cfe_pkg::in_item_t  in_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  output cfe_pkg::out_item_t out_o,
  input  logic               out_stall_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [7:0]         cfg_data_i
);

  logic          cfg_we;
  logic [7:0]    start_q;
  logic          accept, full, empty, pop;
  cfe_pkg::cmd_t cmd, head;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 8'h00;
    end else if (cfg_we) begin
      start_q <= cfg_data_i;
    end
  end

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  cfe_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_i),
    .cmd_o    (cmd)
  );

  cfe_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .cmd_i   (cmd),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (empty),
    .full_o  (full)
  );

  cfe_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_byte_i (start_q),
    .head_i       (head),
    .empty_i      (empty),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_o        (out_o),
    .out_stall_i  (out_stall_i)
  );

endmodule

/* hw/rtl/cfe_checker.sv */
// Port-level checks for the framed packet encoder, bound to the top level.
module cfe_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input cfe_pkg::out_item_t out_o,
  input logic               out_stall_i
);

  // a held result item stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_o))
    else $error("stalled output item changed");

  // error items carry a zero byte and close the frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.status != cfe_pkg::StatusOk |->
      out_o.end_of_frame && out_o.out_byte == 8'h00)
    else $error("malformed error item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_o.status == cfe_pkg::StatusOk ||
      out_o.status == cfe_pkg::StatusTooLong || out_o.status == cfe_pkg::StatusNoFrame)
    else $error("undefined status code");

  // nothing is shown and the input is not stalled while reset is held
  assert property (@(posedge clk_i) !rst_ni && $past(!rst_ni) |->
    !out_valid_o && !in_stall_o)
    else $error("output valid or input stalled during reset");

  // full queue behind a held output cannot drain, so the input stays blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o && out_valid_o && out_stall_i |=> in_stall_o)
    else $error("input released while nothing could drain");

endmodule

bind crc16_frame_encoder_top cfe_checker u_cfe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_o       (out_o),
  .out_stall_i (out_stall_i)
);

/* tb/sv/frame_tb_pkg.sv */
// Operation codes shared by the encoder testbench and its checker.
package frame_tb_pkg;

  localparam logic OpBegin   = 1'b0;
  localparam logic OpPayload = 1'b1;

endpackage

/* tb/sv/frame_checker.sv */
// Checker for the framed packet encoder: predicts the encoded byte stream and compares it.
module frame_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  cfe_pkg::in_item_t  in_item_i,
  input  logic               in_stall_i,
  input  logic               out_valid_i,
  input  cfe_pkg::out_item_t out_item_i,
  input  logic               out_stall_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [7:0]         cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  cfe_pkg::out_item_t encoded_q[$];
  logic [7:0]  start_byte;
  logic [15:0] crc_acc;
  logic [15:0] bytes_left;
  logic        frame_open;
  int          fail_count;

  // Bitwise form of the CCITT update, MSB first.
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c  = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ cfe_pkg::CrcPoly;
      end
    end
    return c;
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic eof, input logic [1:0] st);
    cfe_pkg::out_item_t r;
    r.out_byte     = b;
    r.end_of_frame = eof;
    r.status       = st;
    encoded_q = {encoded_q, r};
  endtask

  task automatic push_covered(input logic [7:0] b);
    push_byte(b, 1'b0, cfe_pkg::StatusOk);
    crc_acc = crc_step(crc_acc, b);
  endtask

  task automatic push_trailer();
    push_byte(crc_acc[7:0], 1'b0, cfe_pkg::StatusOk);
    push_byte(crc_acc[15:8], 1'b1, cfe_pkg::StatusOk);
    frame_open = 1'b0;
    bytes_left = '0;
    crc_acc    = cfe_pkg::CrcInit;
  endtask

  task automatic encode_item(input cfe_pkg::in_item_t it);
    if (it.op == frame_tb_pkg::OpBegin) begin
      if (it.payload_length > cfe_pkg::MaxPayload) begin
        push_byte(8'h00, 1'b1, cfe_pkg::StatusTooLong);
      end else begin
        crc_acc = cfe_pkg::CrcInit;
        push_byte(start_byte, 1'b0, cfe_pkg::StatusOk);
        push_covered(it.frame_type);
        push_covered(it.sequence_req[7:0]);
        push_covered(it.sequence_req[15:8]);
        push_covered(it.payload_length[7:0]);
        push_covered(it.payload_length[15:8]);
        if (it.payload_length == 16'd0) begin
          push_trailer();
        end else begin
          frame_open = 1'b1;
          bytes_left = it.payload_length;
        end
      end
    end else if (!frame_open || bytes_left == 16'd0) begin
      push_byte(8'h00, 1'b1, cfe_pkg::StatusNoFrame);
    end else begin
      push_covered(it.payload_byte);
      bytes_left = bytes_left - 16'd1;
      if (bytes_left == 16'd0) begin
        push_trailer();
      end
    end
  endtask

  task automatic check_output(input cfe_pkg::out_item_t got);
    cfe_pkg::out_item_t want;
    if (encoded_q.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("unexpected output item: byte %02h eof %0b status %0d",
                 got.out_byte, got.end_of_frame, got.status);
      end
    end else begin
      want = encoded_q.pop_front();
      if (got.out_byte !== want.out_byte || got.end_of_frame !== want.end_of_frame ||
          got.status !== want.status) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("mismatch: expected byte %02h eof %0b status %0d, %s",
                   want.out_byte, want.end_of_frame, want.status, "got");
          $display("          actual   byte %02h eof %0b status %0d",
                   got.out_byte, got.end_of_frame, got.status);
        end
      end
    end
  endtask

  // Outputs of an item pass the command queue and the output register first, so
  // checking before predicting at the same edge is safe.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      encoded_q.delete();
      start_byte = 8'h00;
      crc_acc    = cfe_pkg::CrcInit;
      bytes_left = '0;
      frame_open = 1'b0;
      fail_count = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        check_output(out_item_i);
      end
      if (cfg_valid_i && cfg_ready_i) begin
        start_byte = cfg_data_i;
      end
      if (in_valid_i && !in_stall_i) begin
        encode_item(in_item_i);
      end
    end
    fail_count_o = fail_count;
    pending_o    = encoded_q.size();
  end

endmodule

/* tb/sv/testbench.sv */
// Testbench top for the framed packet encoder: clock, reset, stimulus and verdict.
module testbench;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid = 1'b0;
  cfe_pkg::in_item_t  in_data = '0;
  logic               in_stall;
  logic               out_valid;
  cfe_pkg::out_item_t out_data;
  logic               out_stall = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [7:0]         cfg_data = 8'h00;

  int   fail_count;
  int   pending;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   phase_items;
  logic hold_go = 1'b0;
  logic hold_taken = 1'b0;
  int   hold_left = 0;

  always #4 clk = ~clk;

  crc16_frame_encoder_top dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_i       (in_data),
    .in_stall_o (in_stall),
    .out_valid_o(out_valid),
    .out_o      (out_data),
    .out_stall_i(out_stall),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  frame_checker checker_i (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_item_i   (in_data),
    .in_stall_i  (in_stall),
    .out_valid_i (out_valid),
    .out_item_i  (out_data),
    .out_stall_i (out_stall),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_data_i  (cfg_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // Output side: random stall, plus one long hold-off to back up the queue.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_go && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = 60;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  function automatic cfe_pkg::in_item_t make_item(input logic op, input logic [7:0] ftype,
                                                  input logic [15:0] seq,
                                                  input logic [15:0] len,
                                                  input logic [7:0] pb);
    cfe_pkg::in_item_t it;
    it.op             = op;
    it.frame_type     = ftype;
    it.sequence_req   = seq;
    it.payload_length = len;
    it.payload_byte   = pb;
    return it;
  endfunction

  // Unused fields get random junk so every bit toggles.
  function automatic cfe_pkg::in_item_t begin_item(input logic [15:0] len);
    return make_item(frame_tb_pkg::OpBegin, 8'($urandom_range(0, 255)),
                     16'($urandom_range(0, 65535)), len, 8'($urandom_range(0, 255)));
  endfunction

  function automatic cfe_pkg::in_item_t payload_item();
    return make_item(frame_tb_pkg::OpPayload, 8'($urandom_range(0, 255)),
                     16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                     8'($urandom_range(0, 255)));
  endfunction

  // Called and returns at a falling edge.
  task automatic send_item(input cfe_pkg::in_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    phase_items++;
  endtask

  task automatic write_start_byte(input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic send_directed();
    // no frame open
    send_item(make_item(frame_tb_pkg::OpPayload, 8'h00, 16'h0000, 16'h0000, 8'hFF));
    // empty frame
    send_item(make_item(frame_tb_pkg::OpBegin, 8'h00, 16'h0000, 16'h0000, 8'h00));
    send_item(make_item(frame_tb_pkg::OpBegin, 8'hFF, 16'hFFFF, 16'h0000, 8'hFF));
    // too long
    send_item(make_item(frame_tb_pkg::OpBegin, 8'h5A, 16'hA55A, 16'hFFFF, 8'h00));
    send_item(begin_item(16'(cfe_pkg::MaxPayload + 1)));
    // longest accepted
    send_item(make_item(frame_tb_pkg::OpBegin, 8'hA5, 16'h1234,
                        16'(cfe_pkg::MaxPayload), 8'h3C));
    send_item(make_item(frame_tb_pkg::OpPayload, 8'hFF, 16'hFFFF, 16'hFFFF, 8'h00));
    // abandons open frame
    send_item(make_item(frame_tb_pkg::OpBegin, 8'h3C, 16'h8001, 16'h0002, 8'h00));
    send_item(make_item(frame_tb_pkg::OpPayload, 8'h00, 16'h0000, 16'h0000, 8'hFF));
    // open frame survives
    send_item(begin_item(16'd2000));
    // closes frame
    send_item(make_item(frame_tb_pkg::OpPayload, 8'h00, 16'h0000, 16'h0000, 8'h5A));
    // stray
    send_item(make_item(frame_tb_pkg::OpPayload, 8'h00, 16'h0000, 16'h0000, 8'h11));
    send_item(make_item(frame_tb_pkg::OpBegin, 8'h7E, 16'h00FF, 16'h0001, 8'h00));
    send_item(make_item(frame_tb_pkg::OpPayload, 8'h00, 16'h0000, 16'h0000, 8'h80));
  endtask

  // Mostly complete frames; the rest oversize begins, strays and cut-off frames.
  task automatic send_random_frame();
    int kind;
    int len;
    int sent;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      send_item(begin_item(16'($urandom_range(cfe_pkg::MaxPayload + 1, 65535))));
    end else if (kind < 14) begin
      send_item(payload_item());
    end else begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 48) : $urandom_range(0, 6);
      send_item(begin_item(16'(len)));
      sent = (kind < 22 && len > 0) ? $urandom_range(0, len - 1) : len;
      for (int i = 0; i < sent; i++) begin
        send_item(payload_item());
      end
    end
  endtask

  initial begin
    #2000000;
    $display("crc16_frame_encoder_top verification failed");
    $finish;
  end

  initial begin
    logic [7:0] start_values[3];
    int         guard;
    rst_n <= 1'b0;
    start_values[0] = 8'h00;
    start_values[1] = 8'hFF;
    start_values[2] = 8'($urandom_range(1, 254));
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 26;
          recv_idle_pct = 63;
        end
        1: begin
          send_idle_pct = 63;
          recv_idle_pct = 26;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      write_start_byte(start_values[phase]);
      if (phase == 0) begin
        send_directed();
        hold_go <= 1'b1;
      end
      phase_items = 0;
      while (phase_items < 55) begin
        send_random_frame();
      end
      wait_drained();
    end
    guard = 0;
    while (pending != 0 && guard < 50000) begin
      @(negedge clk);
      guard++;
    end
    repeat (8) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("crc16_frame_encoder_top verification clean");
    end else begin
      $display("crc16_frame_encoder_top verification failed");
    end
    $finish;
  end

endmodule
